### hw/rtl/bap_pkg.sv
// Shared types and constants for the alphabet passcode block.
// Depends on nothing; every other file refers to it by scoped names.
package bap_pkg;

  localparam int unsigned SymW     = 8;    // one alphabet symbol, one division digit
  localparam int unsigned CntW     = 8;    // symbol count width
  localparam int unsigned HalfW    = 64;   // one half of the block
  localparam int unsigned BlockW   = 128;  // whole block being divided
  localparam int unsigned NumBytes = BlockW / SymW;
  localparam int unsigned ByteCntW = $clog2(NumBytes);
  localparam int unsigned OpW      = 2;
  localparam int unsigned CfgW     = 6;
  localparam int unsigned LenReset = 4;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR   = 2'd0,
    OP_INSERT  = 2'd1,
    OP_CONVERT = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } top_st_e;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_READ,
    AS_CMP
  } alp_st_e;

  typedef struct packed {
    logic            clear;
    logic            insert;
    logic [SymW-1:0] symbol;
    logic [SymW-1:0] look_addr;
  } alp_req_t;

  typedef struct packed {
    logic            busy;
    logic [CntW-1:0] count;
    logic [SymW-1:0] rdata;
  } alp_stat_t;

  typedef struct packed {
    logic load;
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic            busy;
    logic [SymW-1:0] rem;
  } div_stat_t;

endpackage

### hw/rtl/bap_intf.sv
// Valid/ready channel interfaces for the alphabet passcode block.
// Depends on bap_pkg for the field widths.
interface bap_in_if;
  logic                       valid;
  logic                       ready;
  logic [bap_pkg::OpW-1:0]    operation;
  logic [bap_pkg::SymW-1:0]   symbol;
  logic [bap_pkg::HalfW-1:0]  block_low;
  logic [bap_pkg::HalfW-1:0]  block_high;

  modport source (output valid, output operation, output symbol, output block_low,
                  output block_high, input ready);
  modport sink (input valid, input operation, input symbol, input block_low,
                input block_high, output ready);
endinterface

interface bap_out_if;
  logic                     valid;
  logic                     ready;
  logic [bap_pkg::SymW-1:0] character;
  logic                     last;
  logic                     no_alphabet;

  modport source (output valid, output character, output last, output no_alphabet,
                  input ready);
  modport sink (input valid, input character, input last, input no_alphabet,
                output ready);
endinterface

### hw/rtl/bap_divider.sv
// Byte-serial long divider: shifts the 128-bit value out MSB byte first and the
// quotient bytes back in, one byte per cycle. Depends on bap_pkg.
module bap_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bap_pkg::div_ctl_t          ctl_i,
  input  logic [bap_pkg::BlockW-1:0] value_i,
  input  logic [bap_pkg::SymW-1:0]   divisor_i,
  output bap_pkg::div_stat_t         stat_o
);

  logic [bap_pkg::BlockW-1:0]   wv_q, wv_d;
  logic [bap_pkg::SymW-1:0]     rem_q, rem_d;
  logic [bap_pkg::ByteCntW-1:0] cnt_q, cnt_d;
  logic                         run_q, run_d;
  logic [bap_pkg::SymW-1:0]     qbyte;
  logic [bap_pkg::SymW-1:0]     rnext;
  logic [bap_pkg::SymW:0]       trial;

  // Eight restoring steps on the current byte. The partial remainder stays
  // below the divisor, so each trial value fits in one extra bit.
  always_comb begin
    rnext = rem_q;
    qbyte = '0;
    trial = '0;
    for (int i = bap_pkg::SymW - 1; i >= 0; i--) begin
      trial = {rnext, wv_q[bap_pkg::BlockW-bap_pkg::SymW+i]};
      if (trial >= {1'b0, divisor_i}) begin
        trial    = trial - {1'b0, divisor_i};
        qbyte[i] = 1'b1;
      end
      rnext = trial[bap_pkg::SymW-1:0];
    end
  end

  always_comb begin
    wv_d  = wv_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (ctl_i.load || ctl_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      if (ctl_i.load) begin
        wv_d = value_i;
      end
    end else if (run_q) begin
      wv_d  = {wv_q[bap_pkg::BlockW-bap_pkg::SymW-1:0], qbyte};
      rem_d = rnext;
      cnt_d = cnt_q + bap_pkg::ByteCntW'(1);
      if (cnt_q == bap_pkg::ByteCntW'(bap_pkg::NumBytes - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q  <= wv_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.rem  = rem_q;

endmodule

### hw/rtl/bap_alphabet.sv
// Sorted alphabet store: a single-port-write, registered-read memory plus the
// insertion sequencer that shifts larger entries up by one. Depends on bap_pkg.
module bap_alphabet #(
  parameter int unsigned MAX_SYMBOLS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bap_pkg::alp_req_t  req_i,
  output bap_pkg::alp_stat_t stat_o
);

  localparam int unsigned AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  logic [bap_pkg::SymW-1:0] mem_q [MAX_SYMBOLS];
  logic [bap_pkg::SymW-1:0] rdata_q;

  bap_pkg::alp_st_e         st_q, st_d;
  logic [bap_pkg::CntW-1:0] count_q, count_d;
  logic [AW-1:0]            k_q, k_d;
  logic [bap_pkg::SymW-1:0] sym_q, sym_d;

  logic                     we;
  logic [AW-1:0]            wa;
  logic [bap_pkg::SymW-1:0] wd;
  logic [AW-1:0]            ra;

  // Insertion walks down from the top: every entry above the new symbol moves
  // up one place, and the symbol lands after any equal entries.
  always_comb begin
    st_d    = st_q;
    count_d = count_q;
    k_d     = k_q;
    sym_d   = sym_q;
    we      = 1'b0;
    wa      = k_q;
    wd      = sym_q;
    ra      = req_i.look_addr[AW-1:0];
    case (st_q)
      bap_pkg::AS_IDLE: begin
        if (req_i.clear) begin
          count_d = '0;
        end else if (req_i.insert && (count_q != bap_pkg::CntW'(MAX_SYMBOLS))) begin
          sym_d = req_i.symbol;
          k_d   = count_q[AW-1:0];
          st_d  = bap_pkg::AS_READ;
        end
      end
      bap_pkg::AS_READ: begin
        if (k_q == '0) begin
          we      = 1'b1;
          count_d = count_q + bap_pkg::CntW'(1);
          st_d    = bap_pkg::AS_IDLE;
        end else begin
          ra   = k_q - AW'(1);
          st_d = bap_pkg::AS_CMP;
        end
      end
      bap_pkg::AS_CMP: begin
        we = 1'b1;
        if (rdata_q > sym_q) begin
          wd   = rdata_q;
          k_d  = k_q - AW'(1);
          st_d = bap_pkg::AS_READ;
        end else begin
          count_d = count_q + bap_pkg::CntW'(1);
          st_d    = bap_pkg::AS_IDLE;
        end
      end
      default: begin
        st_d = bap_pkg::AS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= bap_pkg::AS_IDLE;
      count_q <= '0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    sym_q <= sym_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rdata_q <= mem_q[ra];
  end

  assign stat_o.busy  = (st_q != bap_pkg::AS_IDLE);
  assign stat_o.count = count_q;
  assign stat_o.rdata = rdata_q;

endmodule

### hw/rtl/block_to_alphabet_passcode.sv
// Top level of the alphabet passcode block: command sequencer, length register
// and output register. Depends on bap_pkg, bap_intf, bap_alphabet, bap_divider.
//
// Usage: items arrive on in_i (valid/ready). A clear item empties the alphabet,
// an insert item adds one symbol at its sorted place, and a convert item takes
// a 128-bit block and produces passcode_length characters on out_o, the last
// one flagged by last. With an empty alphabet a convert gives a single item
// with no_alphabet and last set and character zero. Operation code 3 is dropped.
// The user must write the length register through cfg_we_i/cfg_wdata_i only
// while idle; the block does not enforce this. Zero acts as one and values
// above MAX_LENGTH act as MAX_LENGTH. Each character costs one pass of the
// byte-serial divider over the 16 bytes of the block, then the move to the
// emit state and a load of the output register. An insert reads and writes
// once for every stored symbol larger than the new one, then writes the new
// symbol. The output register decouples the sides: a new item is accepted
// while a finished character waits, and when the receiver stalls the sequencer
// holds the next character until the register frees up. Reset empties the
// alphabet, sets the length to four and drops any pending output.
module block_to_alphabet_passcode #(
  parameter int unsigned MAX_SYMBOLS = 128,
  parameter int unsigned MAX_LENGTH  = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bap_in_if.sink                   in_i,
  bap_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [bap_pkg::CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned LW = $clog2(MAX_LENGTH + 1);

  bap_pkg::top_st_e         st_q, st_d;
  logic [bap_pkg::CfgW-1:0] len_q;
  logic [LW-1:0]            eff_len;
  logic [LW-1:0]            dig_q, dig_d;
  logic                     is_last;

  logic                     out_valid_q, out_valid_d;
  logic [bap_pkg::SymW-1:0] char_q, char_d;
  logic                     last_q, last_d;
  logic                     noalph_q, noalph_d;
  logic                     out_load;
  logic                     out_free;

  logic                     acc;
  bap_pkg::op_e             op;
  bap_pkg::alp_req_t        areq;
  bap_pkg::alp_stat_t       astat;
  bap_pkg::div_ctl_t        dctl;
  bap_pkg::div_stat_t       dstat;

  bap_alphabet #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_alphabet (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (areq),
    .stat_o(astat)
  );

  bap_divider u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (dctl),
    .value_i  ({in_i.block_high, in_i.block_low}),
    .divisor_i(astat.count),
    .stat_o   (dstat)
  );

  // Effective length after clamping the register into its legal range.
  always_comb begin
    if (len_q == '0) begin
      eff_len = LW'(1);
    end else if (int'(len_q) > int'(MAX_LENGTH)) begin
      eff_len = LW'(MAX_LENGTH);
    end else begin
      eff_len = LW'(len_q);
    end
  end

  assign is_last    = (dig_q == (eff_len - LW'(1)));
  assign in_i.ready = (st_q == bap_pkg::ST_IDLE) && !astat.busy;
  assign acc        = in_i.valid && in_i.ready;
  assign op         = bap_pkg::op_e'(in_i.operation);
  assign out_free   = !out_valid_q || out_o.ready;

  // The remainder drives the lookup address all the time; the alphabet is idle
  // during a convert, so its registered read data follows the final remainder.
  assign areq.clear     = acc && (op == bap_pkg::OP_CLEAR);
  assign areq.insert    = acc && (op == bap_pkg::OP_INSERT);
  assign areq.symbol    = in_i.symbol;
  assign areq.look_addr = dstat.rem;

  always_comb begin
    st_d       = st_q;
    dig_d      = dig_q;
    dctl.load  = 1'b0;
    dctl.start = 1'b0;
    out_load   = 1'b0;
    char_d     = char_q;
    last_d     = last_q;
    noalph_d   = noalph_q;
    case (st_q)
      bap_pkg::ST_IDLE: begin
        if (acc && (op == bap_pkg::OP_CONVERT)) begin
          if (astat.count == '0) begin
            st_d = bap_pkg::ST_ERR;
          end else begin
            dctl.load = 1'b1;
            dig_d     = '0;
            st_d      = bap_pkg::ST_DIV;
          end
        end
      end
      bap_pkg::ST_DIV: begin
        if (!dstat.busy) begin
          st_d = bap_pkg::ST_EMIT;
        end
      end
      bap_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          char_d   = astat.rdata;
          last_d   = is_last;
          noalph_d = 1'b0;
          dig_d    = dig_q + LW'(1);
          if (is_last) begin
            st_d = bap_pkg::ST_IDLE;
          end else begin
            dctl.start = 1'b1;
            st_d       = bap_pkg::ST_DIV;
          end
        end
      end
      bap_pkg::ST_ERR: begin
        if (out_free) begin
          out_load = 1'b1;
          char_d   = '0;
          last_d   = 1'b1;
          noalph_d = 1'b1;
          st_d     = bap_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = bap_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= bap_pkg::ST_IDLE;
      dig_q       <= '0;
      len_q       <= bap_pkg::CfgW'(bap_pkg::LenReset);
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    last_q   <= last_d;
    noalph_q <= noalph_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.character   = char_q;
  assign out_o.last        = last_q;
  assign out_o.no_alphabet = noalph_q;

endmodule

### hw/rtl/bap_checker.sv
// Port-level checks for the alphabet passcode block, bound to its top level.
// Depends on bap_pkg and on the top level's ports.
module bap_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [bap_pkg::OpW-1:0]    in_operation_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [bap_pkg::SymW-1:0]   out_character_i,
  input logic                       out_last_i,
  input logic                       out_no_alphabet_i
);

  // A waiting result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_character_i)
      && $stable(out_last_i) && $stable(out_no_alphabet_i))
    else $error("output item changed while stalled");

  // The error result is always a single, final, zero character.
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_no_alphabet_i |-> out_last_i && (out_character_i == '0))
    else $error("malformed empty-alphabet result");

  // A convert keeps the input closed for at least the next cycle.
  a_conv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_operation_i == bap_pkg::OP_CONVERT) |=> !in_ready_i)
    else $error("input accepted right after a convert");

endmodule

bind block_to_alphabet_passcode bap_checker u_bap_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_operation_i   (in_i.operation),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_character_i  (out_o.character),
  .out_last_i       (out_o.last),
  .out_no_alphabet_i(out_o.no_alphabet)
);
